// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SPFC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define SPFC_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== hw/rtl/spfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spfc_pkg;

  // Longest block before the meter closes it on its own.
  localparam int MAX_BLOCK = 4096;
  // Significant bits of an input sample; the rest is scaled up to Q1.23.
  localparam int SAMPLE_BITS = 24;
  localparam int UP = 24 - SAMPLE_BITS;

  // Sum widths: a square is at most 2^46, summed over MAX_BLOCK samples.
  localparam int ACC_W = 47 + $clog2(MAX_BLOCK);
  localparam int XACC_W = ACC_W + 1;

  // Configuration register indexes.
  localparam logic [1:0] REG_INVERT_LEFT = 2'd0;
  localparam logic [1:0] REG_INVERT_RIGHT = 2'd1;
  localparam logic [1:0] REG_RAMP_COEFF = 2'd2;
  localparam logic [1:0] REG_STEREO_ENABLE = 2'd3;

  // Input word commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_PREPARE = 1'b1;

  // One classified input word waiting for the processing side.
  typedef struct packed {
    logic prepare;
    logic bypass;
    logic last;
    logic signed [23:0] xl;
    logic signed [23:0] xr;
  } item_t;

  // Requests from the sample sequencer to the correlation engine.
  typedef struct packed {
    logic start;
    logic clear;
    logic stereo;
  } corr_req_t;

  // Status of the correlation engine.
  typedef struct packed {
    logic busy;
    logic tap;
    logic signed [15:0] reading;
  } corr_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spfc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spfc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [23:0]         in_left,
  input  logic [23:0]         in_right,
  input  logic                in_last,
  input  logic                in_bypass,
  output logic                item_valid,
  output spfc_pkg::item_t     item,
  input  logic                item_pop
);

  spfc_pkg::item_t q_mem [2];
  spfc_pkg::item_t item_in;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  // Classify the word and scale the samples up to Q1.23.
  always_comb begin
    item_in.prepare = (in_command == spfc_pkg::CMD_PREPARE);
    item_in.bypass  = in_bypass;
    item_in.last    = in_last;
    item_in.xl      = $signed(in_left << spfc_pkg::UP);
    item_in.xr      = $signed(in_right << spfc_pkg::UP);
  end

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign item_valid = (count != 2'd0);
  assign pop        = item_pop && item_valid;
  assign item       = q_mem[rd_ptr];

  // Two-entry queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spfc_corr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spfc_corr (
  input  logic                                clk,
  input  logic                                rst,
  input  spfc_pkg::corr_req_t                 req,
  input  logic signed [spfc_pkg::XACC_W-1:0]  sum_cross,
  input  logic [spfc_pkg::ACC_W-1:0]          sum_left_sq,
  input  logic [spfc_pkg::ACC_W-1:0]          sum_right_sq,
  output spfc_pkg::corr_stat_t                stat
);

  localparam int ACC_W = spfc_pkg::ACC_W;
  localparam int XACC_W = spfc_pkg::XACC_W;

  localparam logic [3:0] C_IDLE   = 4'd0;
  localparam logic [3:0] C_NORM   = 4'd1;
  localparam logic [3:0] C_PROD   = 4'd2;
  localparam logic [3:0] C_SQRT   = 4'd3;
  localparam logic [3:0] C_DCHK   = 4'd4;
  localparam logic [3:0] C_DIV    = 4'd5;
  localparam logic [3:0] C_CLAMP  = 4'd6;
  localparam logic [3:0] C_SMUL   = 4'd7;
  localparam logic [3:0] C_SMOOTH = 4'd8;

  localparam logic [12:0]        SILENCE_SQ = 13'd4952;
  localparam logic [4:0]         SQRT_LAST  = 5'd29;
  localparam logic [3:0]         DIV_LAST   = 4'd15;
  localparam logic [16:0]        Q_SAT      = 17'd32768;
  localparam logic signed [15:0] SMOOTH_Q16 = 16'sd9830;

  logic [3:0]              state;
  logic [ACC_W-1:0]        ll;
  logic [ACC_W-1:0]        rr;
  logic [ACC_W-1:0]        mag;
  logic                    neg;
  logic [59:0]             rad;
  logic [29:0]             root;
  logic [30:0]             rem;
  logic [4:0]              iter;
  logic [45:0]             drem;
  logic [45:0]             dsh;
  logic [15:0]             quo;
  logic                    qsat;
  logic [3:0]              dcnt;
  logic signed [15:0]      cval;
  logic signed [32:0]      sprod;
  logic signed [15:0]      smoothed;
  logic                    primed;
  logic                    tap;

  logic                    is_zero;
  logic                    is_silent;
  logic [25:0]             small_prod;
  logic [XACC_W-1:0]       abs_cross;
  logic                    big_l;
  logic                    big_r;
  logic [32:0]             sq_cur;
  logic [32:0]             sq_trial;
  logic [16:0]             qc;
  logic signed [17:0]      cwide;
  logic signed [15:0]      cnext;
  logic signed [16:0]      dlt;
  logic signed [32:0]      radj;
  logic signed [17:0]      step;
  logic signed [17:0]      snew;

  // Entry checks: empty channel, or energy product below the silence floor.
  always_comb begin
    is_zero    = (sum_left_sq == '0) || (sum_right_sq == '0);
    small_prod = sum_left_sq[12:0] * sum_right_sq[12:0];
    is_silent  = (sum_left_sq < ACC_W'(SILENCE_SQ)) && (sum_right_sq < ACC_W'(SILENCE_SQ))
                 && (small_prod < 26'(SILENCE_SQ));
    abs_cross  = sum_cross[XACC_W-1] ? XACC_W'(-sum_cross) : XACC_W'(sum_cross);
  end

  // Normalization: each energy drops by 2 bits until it is below 2^30.
  assign big_l = |ll[ACC_W-1:30];
  assign big_r = |rr[ACC_W-1:30];

  // One root bit per cycle from the top two radicand bits.
  assign sq_cur   = {rem, rad[59:58]};
  assign sq_trial = {1'b0, root, 2'b01};

  // Quotient to a signed Q1.15 value.
  always_comb begin
    qc    = qsat ? Q_SAT : ((17'(quo) > Q_SAT) ? Q_SAT : 17'(quo));
    cwide = neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    cnext = (cwide > 18'sd32767) ? 16'sd32767 : 16'(cwide);
  end

  // Smoothing by 0.15, rounded to nearest with floor.
  always_comb begin
    dlt  = 17'(cval) - 17'(smoothed);
    radj = sprod + 33'sd32768;
    step = 18'(radj >>> 16);
    snew = 18'(smoothed) + step;
  end

  assign stat.busy    = (state != C_IDLE);
  assign stat.tap     = tap;
  assign stat.reading = smoothed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      smoothed <= '0;
      primed   <= 1'b0;
      tap      <= 1'b0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (req.clear) begin
            smoothed <= '0;
            primed   <= 1'b0;
            tap      <= 1'b0;
          end else if (req.start) begin
            if (!req.stereo) begin
              tap    <= 1'b0;
              primed <= 1'b0;
            end else if (!is_zero && !is_silent) begin
              ll    <= sum_left_sq;
              rr    <= sum_right_sq;
              neg   <= sum_cross[XACC_W-1];
              mag   <= abs_cross[ACC_W-1:0];
              state <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (big_l) begin
            ll <= ll >> 2;
          end
          if (big_r) begin
            rr <= rr >> 2;
          end
          // The cross sum loses half of the combined energy shift.
          if (big_l && big_r) begin
            mag <= mag >> 2;
          end else if (big_l || big_r) begin
            mag <= mag >> 1;
          end else begin
            state <= C_PROD;
          end
        end
        C_PROD: begin
          rad   <= ll[29:0] * rr[29:0];
          root  <= '0;
          rem   <= '0;
          iter  <= '0;
          state <= C_SQRT;
        end
        C_SQRT: begin
          if (sq_cur >= sq_trial) begin
            rem  <= 31'(sq_cur - sq_trial);
            root <= {root[28:0], 1'b1};
          end else begin
            rem  <= 31'(sq_cur);
            root <= {root[28:0], 1'b0};
          end
          rad  <= rad << 2;
          iter <= iter + 5'd1;
          if (iter == SQRT_LAST) begin
            state <= C_DCHK;
          end
        end
        C_DCHK: begin
          // A quotient of 2^16 or more saturates without dividing.
          if (root == '0) begin
            state <= C_IDLE;
          end else if (mag >= ACC_W'({root, 1'b0})) begin
            qsat  <= 1'b1;
            state <= C_CLAMP;
          end else begin
            qsat  <= 1'b0;
            drem  <= {mag[30:0], 15'd0};
            dsh   <= {1'b0, root, 15'd0};
            quo   <= '0;
            dcnt  <= '0;
            state <= C_DIV;
          end
        end
        C_DIV: begin
          if (drem >= dsh) begin
            drem <= drem - dsh;
            quo  <= {quo[14:0], 1'b1};
          end else begin
            quo  <= {quo[14:0], 1'b0};
          end
          dsh  <= dsh >> 1;
          dcnt <= dcnt + 4'd1;
          if (dcnt == DIV_LAST) begin
            state <= C_CLAMP;
          end
        end
        C_CLAMP: begin
          cval  <= cnext;
          state <= C_SMUL;
        end
        C_SMUL: begin
          // The first reading is taken as it is.
          if (!primed) begin
            smoothed <= cval;
            primed   <= 1'b1;
            tap      <= 1'b1;
            state    <= C_IDLE;
          end else begin
            sprod <= dlt * SMOOTH_Q16;
            state <= C_SMOOTH;
          end
        end
        C_SMOOTH: begin
          if (snew > 18'sd32767) begin
            smoothed <= 16'sd32767;
          end else if (snew < -18'sd32768) begin
            smoothed <= -16'sd32768;
          end else begin
            smoothed <= 16'(snew);
          end
          tap   <= 1'b1;
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spfc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spfc_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                invert_left,
  input  logic                                invert_right,
  input  logic [23:0]                         ramp_coeff,
  input  logic                                stereo_enable,
  input  logic                                item_valid,
  input  spfc_pkg::item_t                     item,
  output logic                                item_pop,
  output spfc_pkg::corr_req_t                 corr_req,
  input  spfc_pkg::corr_stat_t                corr_stat,
  output logic signed [spfc_pkg::XACC_W-1:0]  sum_cross,
  output logic [spfc_pkg::ACC_W-1:0]          sum_left_sq,
  output logic [spfc_pkg::ACC_W-1:0]          sum_right_sq,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [23:0]                  left_out,
  output logic signed [23:0]                  right_out,
  output logic                                reading_valid,
  output logic signed [15:0]                  reading
);

  localparam int ACC_W = spfc_pkg::ACC_W;
  localparam int XACC_W = spfc_pkg::XACC_W;
  localparam int CNT_W = $clog2(spfc_pkg::MAX_BLOCK + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RAMP = 4'd1;
  localparam logic [3:0] ST_GAIN = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_SAT  = 4'd4;
  localparam logic [3:0] ST_SQ   = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_WAIT = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  localparam logic signed [24:0] GAIN_POS = 25'sd8388608;
  localparam logic signed [24:0] GAIN_NEG = -25'sd8388608;

  logic [3:0]              state;
  spfc_pkg::item_t         cur;
  logic signed [24:0]      gain_l;
  logic signed [24:0]      gain_r;
  logic signed [50:0]      prod_l;
  logic signed [50:0]      prod_r;
  logic signed [48:0]      mul_l;
  logic signed [48:0]      mul_r;
  logic signed [23:0]      y_l;
  logic signed [23:0]      y_r;
  logic [46:0]             sq_ll;
  logic [46:0]             sq_rr;
  logic signed [47:0]      sq_lr;
  logic [CNT_W-1:0]        count;
  logic                    blk_end;

  logic signed [24:0]      tgt_l;
  logic signed [24:0]      tgt_r;
  logic signed [24:0]      inv_l;
  logic signed [24:0]      inv_r;
  logic signed [25:0]      diff_l;
  logic signed [25:0]      diff_r;
  logic signed [24:0]      coeff_s;
  logic signed [50:0]      prod_l_next;
  logic signed [50:0]      prod_r_next;
  logic signed [48:0]      mul_l_next;
  logic signed [48:0]      mul_r_next;
  logic signed [47:0]      pll;
  logic signed [47:0]      prr;
  logic [CNT_W-1:0]        cnt_next;
  logic                    load;

  // Gain step toward the target, the product truncated toward zero.
  function automatic logic signed [24:0] ramp_step(input logic signed [24:0] tgt,
                                                   input logic signed [50:0] p);
    logic signed [50:0] a;
    logic signed [26:0] q;
    a = p[50] ? (p + 51'sd16777215) : p;
    q = 27'(a >>> 24);
    return 25'(27'(tgt) + q);
  endfunction

  // Round a Q3.46 product to Q1.23 and saturate.
  function automatic logic signed [23:0] sat_q23(input logic signed [48:0] v);
    logic signed [48:0] r;
    logic signed [25:0] s;
    r = v + 49'sd4194304;
    s = 26'(r >>> 23);
    if (s > 26'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (s < -26'sd8388608) begin
      return 24'sh800000;
    end else begin
      return 24'(s);
    end
  endfunction

  // Gain targets for samples and for a prepare.
  always_comb begin
    tgt_l = (cur.bypass || !invert_left) ? GAIN_POS : GAIN_NEG;
    tgt_r = (cur.bypass || !invert_right) ? GAIN_POS : GAIN_NEG;
    inv_l = invert_left ? GAIN_NEG : GAIN_POS;
    inv_r = invert_right ? GAIN_NEG : GAIN_POS;
  end

  // Datapath terms, one multiplier rank per state.
  always_comb begin
    coeff_s     = $signed({1'b0, ramp_coeff});
    diff_l      = 26'(gain_l) - 26'(tgt_l);
    diff_r      = 26'(gain_r) - 26'(tgt_r);
    prod_l_next = diff_l * coeff_s;
    prod_r_next = diff_r * coeff_s;
    mul_l_next  = cur.xl * gain_l;
    mul_r_next  = cur.xr * gain_r;
    pll         = y_l * y_l;
    prr         = y_r * y_r;
    cnt_next    = count + CNT_W'(1);
  end

  assign item_pop        = (state == ST_IDLE) && item_valid;
  assign corr_req.start  = (state == ST_FIN) && blk_end;
  assign corr_req.clear  = item_pop && item.prepare;
  assign corr_req.stereo = stereo_enable;
  assign load            = (state == ST_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      gain_l       <= GAIN_POS;
      gain_r       <= GAIN_POS;
      sum_cross    <= '0;
      sum_left_sq  <= '0;
      sum_right_sq <= '0;
      count        <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Output register: filled by the sequencer, emptied by the sink.
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cur <= item;
            if (item.prepare) begin
              gain_l       <= inv_l;
              gain_r       <= inv_r;
              sum_cross    <= '0;
              sum_left_sq  <= '0;
              sum_right_sq <= '0;
              count        <= '0;
              state        <= ST_OUT;
            end else begin
              state <= ST_RAMP;
            end
          end
        end
        ST_RAMP: begin
          prod_l <= prod_l_next;
          prod_r <= prod_r_next;
          state  <= ST_GAIN;
        end
        ST_GAIN: begin
          gain_l <= ramp_step(tgt_l, prod_l);
          gain_r <= ramp_step(tgt_r, prod_r);
          state  <= ST_MUL;
        end
        ST_MUL: begin
          mul_l <= mul_l_next;
          mul_r <= mul_r_next;
          state <= ST_SAT;
        end
        ST_SAT: begin
          y_l   <= sat_q23(mul_l);
          y_r   <= stereo_enable ? sat_q23(mul_r) : '0;
          state <= ST_SQ;
        end
        ST_SQ: begin
          sq_ll <= pll[46:0];
          sq_rr <= prr[46:0];
          sq_lr <= y_l * y_r;
          state <= ST_ACC;
        end
        ST_ACC: begin
          sum_left_sq  <= sum_left_sq + ACC_W'(sq_ll);
          sum_right_sq <= sum_right_sq + ACC_W'(sq_rr);
          sum_cross    <= sum_cross + XACC_W'(sq_lr);
          count        <= cnt_next;
          blk_end      <= cur.last || (cnt_next >= CNT_W'(spfc_pkg::MAX_BLOCK));
          state        <= ST_FIN;
        end
        ST_FIN: begin
          // The engine latches the sums on this edge; the next block starts clean.
          if (blk_end) begin
            sum_cross    <= '0;
            sum_left_sq  <= '0;
            sum_right_sq <= '0;
            count        <= '0;
            state        <= ST_WAIT;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_WAIT: begin
          if (!corr_stat.busy) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (load) begin
            left_out      <= cur.prepare ? '0 : 24'(y_l >>> spfc_pkg::UP);
            right_out     <= cur.prepare ? '0 : 24'(y_r >>> spfc_pkg::UP);
            reading_valid <= !cur.prepare && corr_stat.tap;
            reading       <= (!cur.prepare && corr_stat.tap) ? corr_stat.reading : '0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stereo_polarity_flip_with_correlation.sv =====
// A sample word passes the ramp, multiply, saturate, square and accumulate sequencer; a
// prepare word goes straight to the output. The sequencer takes a new word only after the
// previous one is in the output register. A word that closes a block also waits for the
// correlation engine (normalize, product and square root, check and divide, smoothing, hand-back).
// Reset (synchronous, active high) restores the register defaults, sets both gains to +1,
// clears the sums and the reading; there is no memory clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stereo_polarity_flip_with_correlation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // left_in[23:0], right_in[47:24], bypass[48], zero pad
  input  logic        s_axis_tlast,
  input  logic [0:0]  s_axis_tuser,   // command[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // left_out[23:0], right_out[47:24],
                                      // reading_valid[48], reading[64:49], zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_data
);

  logic                                invert_left;
  logic                                invert_right;
  logic [23:0]                         ramp_coeff;
  logic                                stereo_enable;

  logic                                item_valid;
  spfc_pkg::item_t                     item;
  logic                                item_pop;
  spfc_pkg::corr_req_t                 corr_req;
  spfc_pkg::corr_stat_t                corr_stat;
  logic signed [spfc_pkg::XACC_W-1:0]  sum_cross;
  logic [spfc_pkg::ACC_W-1:0]          sum_left_sq;
  logic [spfc_pkg::ACC_W-1:0]          sum_right_sq;
  logic signed [23:0]                  left_out;
  logic signed [23:0]                  right_out;
  logic                                reading_valid;
  logic signed [15:0]                  reading;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_left   <= 1'b0;
      invert_right  <= 1'b0;
      ramp_coeff    <= 24'd16701299;
      stereo_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        spfc_pkg::REG_INVERT_LEFT:   invert_left   <= cfg_data[0];
        spfc_pkg::REG_INVERT_RIGHT:  invert_right  <= cfg_data[0];
        spfc_pkg::REG_RAMP_COEFF:    ramp_coeff    <= cfg_data;
        spfc_pkg::REG_STEREO_ENABLE: stereo_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Intake and queue.
  spfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_command (s_axis_tuser[0]),
    .in_left    (s_axis_tdata[23:0]),
    .in_right   (s_axis_tdata[47:24]),
    .in_last    (s_axis_tlast),
    .in_bypass  (s_axis_tdata[48]),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // Gain ramp, gain multiply and block sums.
  spfc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .invert_left   (invert_left),
    .invert_right  (invert_right),
    .ramp_coeff    (ramp_coeff),
    .stereo_enable (stereo_enable),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop),
    .corr_req      (corr_req),
    .corr_stat     (corr_stat),
    .sum_cross     (sum_cross),
    .sum_left_sq   (sum_left_sq),
    .sum_right_sq  (sum_right_sq),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .left_out      (left_out),
    .right_out     (right_out),
    .reading_valid (reading_valid),
    .reading       (reading)
  );

  // End-of-block correlation and smoothing.
  spfc_corr u_corr (
    .clk          (clk),
    .rst          (rst),
    .req          (corr_req),
    .sum_cross    (sum_cross),
    .sum_left_sq  (sum_left_sq),
    .sum_right_sq (sum_right_sq),
    .stat         (corr_stat)
  );

  assign m_axis_tdata = {7'd0, reading, reading_valid, right_out, left_out};

endmodule

`default_nettype wire

// ===== hw/rtl/spfc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spfc_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [71:0] m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [23:0] cfg_data
);

  logic stereo_q;

  // Track the stereo setting as seen on the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_q <= 1'b1;
    end else if (cfg_we && (cfg_addr == spfc_pkg::REG_STEREO_ENABLE)) begin
      stereo_q <= cfg_data[0];
    end
  end

  `SPFC_ASSERT_ALWAYS(a_no_word_after_reset, clk, rst |=> !m_axis_tvalid, "word after reset")
  `SPFC_ASSERT(a_hold_stalled, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
  `SPFC_ASSERT(a_no_reading_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[48] |-> m_axis_tdata[64:49] == 16'd0, "reading without valid flag")
  `SPFC_ASSERT(a_mono_right_zero, clk, rst, m_axis_tvalid && !stereo_q |-> m_axis_tdata[47:24] == 24'd0, "right channel in mono")

endmodule

bind stereo_polarity_flip_with_correlation spfc_checker u_spfc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_we        (cfg_we),
  .cfg_addr      (cfg_addr),
  .cfg_data      (cfg_data)
);

`default_nettype wire
